/* sv/srss_pkg.sv */
// ----------------------------------------------------------------------------
// srss_pkg: shared types and constants of the score record Shell sorter
// Defaults for the top-level parameters, gap sequence constants, the
// controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
package srss_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int SCORE_BITS_DEF = 32;
	localparam int INDEX_BITS_DEF = 32;

	// Gap sequence h' = 3h + 1, walked back by (h - 1) / 3
	localparam int GAP_MUL   = 3;
	localparam int GAP_ADD   = 1;
	// (x * 171) >> 9 equals x / 3 for every x below 128
	localparam int GAP_RECIP = 171;
	localparam int GAP_SHIFT = 9;

	// Write data select
	localparam logic [1:0] WSEL_IN   = 2'd0;
	localparam logic [1:0] WSEL_RD   = 2'd1;
	localparam logic [1:0] WSEL_TEMP = 2'd2;

	typedef struct packed {
		logic       we;
		logic [1:0] wsel;
		logic       take_t;
		logic       load_out;
		logic       out_final;
	} cmd_t;

	typedef struct packed {
		logic greater;
		logic out_free;
	} status_t;

endpackage

/* sv/srss_ram.sv */
// ----------------------------------------------------------------------------
// srss_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module srss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/srss_dp.sv */
// ----------------------------------------------------------------------------
// srss_dp: record store, insertion temp register and output register
// Holds the records in RAM, compares the temp score against the read score,
// and keeps one output request waiting for the downstream side.
// ----------------------------------------------------------------------------
module srss_dp #(
	parameter int DEPTH      = srss_pkg::DEPTH_DEF,
	parameter int SCORE_BITS = srss_pkg::SCORE_BITS_DEF,
	parameter int INDEX_BITS = srss_pkg::INDEX_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [SCORE_BITS-1:0]    in_score,
	input  logic [INDEX_BITS-1:0]    in_index,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  srss_pkg::cmd_t           cmd,
	output srss_pkg::status_t        status,
	output logic [SCORE_BITS-1:0]    out_score,
	output logic [INDEX_BITS-1:0]    out_index,
	output logic                     out_final,
	output logic                     out_valid,
	input  logic                     out_ready
);

	import srss_pkg::*;

	localparam int REC_W = SCORE_BITS + INDEX_BITS;

	logic [REC_W-1:0] rdata;
	logic [REC_W-1:0] wdata;
	logic [REC_W-1:0] temp_q;
	logic [REC_W-1:0] out_rec_q;
	logic             out_final_q;
	logic             out_valid_q;

	srss_ram #(
		.WIDTH (REC_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		case (cmd.wsel)
			WSEL_IN:   wdata = {in_index, in_score};
			WSEL_RD:   wdata = rdata;
			WSEL_TEMP: wdata = temp_q;
			default:   wdata = temp_q;
		endcase
	end

	assign status.greater  = $signed(temp_q[SCORE_BITS-1:0]) > $signed(rdata[SCORE_BITS-1:0]);
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.take_t) begin
			temp_q <= rdata;
		end
		if (cmd.load_out) begin
			out_rec_q   <= rdata;
			out_final_q <= cmd.out_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_score = out_rec_q[SCORE_BITS-1:0];
	assign out_index = out_rec_q[REC_W-1:SCORE_BITS];
	assign out_final = out_final_q;
	assign out_valid = out_valid_q;

endmodule

/* sv/srss_ctrl.sv */
// ----------------------------------------------------------------------------
// srss_ctrl: load / sort / emit sequencer
// Counts records in, walks the gap sequence and the gapped insertion passes,
// then reads the records out one request at a time.
// ----------------------------------------------------------------------------
module srss_ctrl #(
	parameter int DEPTH = srss_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_last,
	output logic                     in_ready,
	output logic [$clog2(DEPTH)-1:0] raddr,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output srss_pkg::cmd_t           cmd,
	input  srss_pkg::status_t        status
);

	import srss_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = CNT_W + GAP_SHIFT;

	localparam logic [2:0] S_LOAD    = 3'd0;
	localparam logic [2:0] S_GROW    = 3'd1;
	localparam logic [2:0] S_RD_I    = 3'd2;
	localparam logic [2:0] S_TAKE_I  = 3'd3;
	localparam logic [2:0] S_CMP     = 3'd4;
	localparam logic [2:0] S_PLACE   = 3'd5;
	localparam logic [2:0] S_EMIT_RD = 3'd6;
	localparam logic [2:0] S_EMIT_LD = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] gap_q, gap_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] k_q, k_d;

	logic [CNT_W+1:0]  gap_grow;
	logic [PROD_W-1:0] gap_prod;
	logic [CNT_W-1:0]  gap_prev;
	logic [CNT_W-1:0]  i_inc;
	logic [CNT_W-1:0]  i_back;
	logic [CNT_W-1:0]  j_dn;
	logic [CNT_W-1:0]  j_back;
	logic              advance;

	assign gap_grow = {2'b00, gap_q} * (CNT_W + 2)'(GAP_MUL) + (CNT_W + 2)'(GAP_ADD);
	// (gap - 1) / 3 by reciprocal multiply
	assign gap_prod = PROD_W'(gap_q - 1'b1) * PROD_W'(GAP_RECIP);
	assign gap_prev = gap_prod[PROD_W-1:GAP_SHIFT];
	assign i_inc    = i_q + 1'b1;
	assign i_back   = i_q - gap_q;
	assign j_dn     = j_q - gap_q;
	assign j_back   = j_dn - gap_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		gap_d    = gap_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		in_ready = 1'b0;
		raddr    = i_q[ADDR_W-1:0];
		waddr    = j_q[ADDR_W-1:0];
		cmd      = '0;
		advance  = 1'b0;

		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				waddr    = cnt_q[ADDR_W-1:0];
				if (in_valid) begin
					cmd.we   = 1'b1;
					cmd.wsel = WSEL_IN;
					cnt_d    = cnt_q + 1'b1;
					if (in_last || cnt_q == CNT_W'(DEPTH - 1)) begin
						gap_d = CNT_W'(1);
						k_d   = '0;
						// a lone record needs no pass
						state_d = (cnt_q == '0) ? S_EMIT_RD : S_GROW;
					end
				end
			end
			S_GROW: begin
				if (gap_grow < {2'b00, cnt_q}) begin
					gap_d = gap_grow[CNT_W-1:0];
				end else begin
					i_d     = gap_q;
					state_d = S_RD_I;
				end
			end
			S_RD_I: begin
				raddr   = i_q[ADDR_W-1:0];
				state_d = S_TAKE_I;
			end
			S_TAKE_I: begin
				cmd.take_t = 1'b1;
				j_d        = i_q;
				raddr      = i_back[ADDR_W-1:0];
				state_d    = S_CMP;
			end
			S_CMP: begin
				cmd.we = 1'b1;
				if (status.greater) begin
					cmd.wsel = WSEL_RD;
					j_d      = j_dn;
					if (j_dn >= gap_q) begin
						raddr = j_back[ADDR_W-1:0];
					end else begin
						state_d = S_PLACE;
					end
				end else begin
					cmd.wsel = WSEL_TEMP;
					advance  = 1'b1;
				end
			end
			S_PLACE: begin
				cmd.we   = 1'b1;
				cmd.wsel = WSEL_TEMP;
				advance  = 1'b1;
			end
			S_EMIT_RD: begin
				raddr   = k_q[ADDR_W-1:0];
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				raddr = k_q[ADDR_W-1:0];
				if (status.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_final = (k_q + 1'b1 == cnt_q);
					if (k_q + 1'b1 == cnt_q) begin
						cnt_d   = '0;
						state_d = S_LOAD;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase

		// next element of the pass, next gap, or done
		if (advance) begin
			if (i_inc < cnt_q) begin
				i_d     = i_inc;
				raddr   = i_inc[ADDR_W-1:0];
				state_d = S_TAKE_I;
			end else if (gap_q == CNT_W'(1)) begin
				k_d     = '0;
				state_d = S_EMIT_RD;
			end else begin
				// go through S_RD_I first: the last write may hit the new start address
				gap_d   = gap_prev;
				i_d     = gap_prev;
				state_d = S_RD_I;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			gap_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			gap_q   <= gap_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

endmodule

/* sv/score_record_shell_sorter_core.sv */
// ----------------------------------------------------------------------------
// score_record_shell_sorter_core: stream Shell sorter for score records
// Collects up to DEPTH records, sorts them greatest score first with Shell
// sort (gaps 1, 4, 13, 40, ...), then streams them out with tlast on the last.
// ----------------------------------------------------------------------------
// Load: one record per cycle. Sort: grow the gap to its first value, then for
// each gap g take elements g to n - 1 into temp and move lower-score records
// up by g; one RAM port pair serves every step. Emit: read each record, then
// load it into the output register when free. No set overlaps another.
// arst_n clears the sequencer and the output valid; the record RAM is not
// cleared and needs no clearing pass.
module score_record_shell_sorter_core #(
	parameter int DEPTH      = srss_pkg::DEPTH_DEF,
	parameter int SCORE_BITS = srss_pkg::SCORE_BITS_DEF,
	parameter int INDEX_BITS = srss_pkg::INDEX_BITS_DEF,
	parameter int DATA_W     = ((SCORE_BITS + INDEX_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // score, cell_index, zero pad
	input  logic              s_axis_tlast,  // last_item
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // sorted_score, sorted_index, zero pad
	output logic              m_axis_tlast   // final_result
);

	import srss_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);

	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	cmd_t                  cmd;
	status_t               status;
	logic [SCORE_BITS-1:0] out_score;
	logic [INDEX_BITS-1:0] out_index;

	srss_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.raddr    (raddr),
		.waddr    (waddr),
		.cmd      (cmd),
		.status   (status)
	);

	srss_dp #(
		.DEPTH      (DEPTH),
		.SCORE_BITS (SCORE_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_score  (s_axis_tdata[SCORE_BITS-1:0]),
		.in_index  (s_axis_tdata[SCORE_BITS+INDEX_BITS-1:SCORE_BITS]),
		.raddr     (raddr),
		.waddr     (waddr),
		.cmd       (cmd),
		.status    (status),
		.out_score (out_score),
		.out_index (out_index),
		.out_final (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = DATA_W'({out_index, out_score});

endmodule
